[rtl/display_init_list_sequencer_defines.svh]
// assertion macros for the display init list sequencer
`ifndef DISPLAY_INIT_LIST_SEQUENCER_DEFINES_SVH
`define DISPLAY_INIT_LIST_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
// antecedent holds, consequent must hold in the next cycle
`define DILS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dils: next-cycle check failed");
// antecedent holds, consequent must hold in the same cycle
`define DILS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dils: same-cycle check failed");
`else
`define DILS_ASSERT_NEXT(label, ante, cons)
`define DILS_ASSERT_NOW(label, ante, cons)
`endif

`endif

[rtl/dils_pkg.sv]
// types and constants shared by the init list sequencer modules
`timescale 1ns / 1ps
package dils_pkg;

  localparam int unsigned DelayFlagBit = 7;
  localparam logic [7:0]  LongDelayKey = 8'd255;
  localparam logic [8:0]  LongDelayMs  = 9'd500;
  localparam logic [7:0]  CountReset   = 8'd14;

  typedef enum logic [2:0] {
    PH_CMD   = 3'd0,
    PH_COUNT = 3'd1,
    PH_ARGS  = 3'd2,
    PH_DELAY = 3'd3,
    PH_DONE  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_DELAY = 2'd2
  } kind_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] held_command;
    logic [6:0] args_left;
    logic       delay_follows;
    logic [7:0] commands_left;
  } dils_state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [8:0] delay_ms;
    logic       last;
  } dils_result_t;

endpackage

[rtl/dils_step.sv]
// next-state and result logic for one list byte
`timescale 1ns / 1ps
module dils_step import dils_pkg::*; (
  input  dils_state_t  state,
  input  logic [7:0]   list_byte,
  output dils_state_t  state_next,
  output logic         result_valid,
  output dils_result_t result
);

  logic [7:0] cmds_dec;
  logic       cmds_end;
  logic [6:0] args_dec;
  logic [6:0] count_args;
  logic       count_delay;

  assign cmds_dec    = state.commands_left - 8'd1;
  assign cmds_end    = (cmds_dec == 8'd0);
  assign args_dec    = state.args_left - 7'd1;
  assign count_args  = list_byte[6:0];
  assign count_delay = list_byte[DelayFlagBit];

  always_comb begin
    state_next   = state;
    result_valid = 1'b0;
    result       = '{kind: KIND_CMD, out_byte: 8'd0, delay_ms: 9'd0, last: 1'b0};
    unique case (state.phase)
      PH_CMD: begin
        state_next.held_command = list_byte;
        state_next.phase        = PH_COUNT;
      end
      PH_COUNT: begin
        state_next.args_left     = count_args;
        state_next.delay_follows = count_delay;
        result_valid             = 1'b1;
        result.kind              = KIND_CMD;
        result.out_byte          = state.held_command;
        if (count_args != 7'd0) begin
          state_next.phase = PH_ARGS;
        end else if (count_delay) begin
          state_next.phase = PH_DELAY;
        end else begin
          state_next.commands_left = cmds_dec;
          state_next.phase         = cmds_end ? PH_DONE : PH_CMD;
          result.last              = cmds_end;
        end
      end
      PH_ARGS: begin
        state_next.args_left = args_dec;
        result_valid         = 1'b1;
        result.kind          = KIND_DATA;
        result.out_byte      = list_byte;
        if (args_dec == 7'd0) begin
          if (state.delay_follows) begin
            state_next.phase = PH_DELAY;
          end else begin
            state_next.commands_left = cmds_dec;
            state_next.phase         = cmds_end ? PH_DONE : PH_CMD;
            result.last              = cmds_end;
          end
        end
      end
      PH_DELAY: begin
        result_valid             = 1'b1;
        result.kind              = KIND_DELAY;
        result.delay_ms          = (list_byte == LongDelayKey) ? LongDelayMs
                                                                : {1'b0, list_byte};
        state_next.commands_left = cmds_dec;
        state_next.phase         = cmds_end ? PH_DONE : PH_CMD;
        result.last              = cmds_end;
      end
      default: begin
        // done: bytes are dropped
      end
    endcase
  end

endmodule

[rtl/dils_out_reg.sv]
// result register facing the output channel
`timescale 1ns / 1ps
module dils_out_reg import dils_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  dils_result_t load_result,
  input  logic         out_stall,
  output logic         can_load,
  output logic         out_valid,
  output dils_result_t out_result
);

  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
    if (can_load && load) begin
      out_result <= load_result;
    end
  end

endmodule

[rtl/display_init_list_sequencer.sv]
// top level of the display init list sequencer
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  input   | in        | in_valid / in_stall    | list_byte
//  output  | out       | out_valid / out_stall  | kind, out_byte, delay_ms, last
//  config  | in        | cfg_we (no wait)       | cfg_wdata = command_count
//
//  one list byte per cycle is taken while in_stall is low; a byte is held in the input register
//  and its result (if any) is loaded into the result register as the byte moves on
//  rst clears control state and loads a command count of 14
//  a config write reloads the command count and restarts the list parser
//  in_stall rises only while the input register is full and the result register
//  holds a beat that the output side stalls
`timescale 1ns / 1ps
`include "display_init_list_sequencer_defines.svh"
module display_init_list_sequencer import dils_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] list_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [8:0] delay_ms,
  output logic       last,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // input register
  logic       in_full;
  logic [7:0] in_byte;

  // parser state and its next value
  dils_state_t  state;
  dils_state_t  state_next;
  logic         step_valid;
  dils_result_t step_result;

  // result register handshake
  logic         can_load;
  logic         advance;
  logic         load_beat;
  dils_result_t out_result;

  // the held byte moves on once the result register can take its beat
  assign advance   = in_full && can_load;
  assign in_stall  = in_full && !can_load;
  assign load_beat = advance && step_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_byte <= list_byte;
    end
  end

  dils_step u_step (
    .state        (state),
    .list_byte    (in_byte),
    .state_next   (state_next),
    .result_valid (step_valid),
    .result       (step_result)
  );

  // config write wins: it restarts the list at a fresh entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= (CountReset == 8'd0) ? PH_DONE : PH_CMD;
      state.held_command  <= 8'd0;
      state.args_left     <= 7'd0;
      state.delay_follows <= 1'b0;
      state.commands_left <= CountReset;
    end else if (cfg_we) begin
      state.phase         <= (cfg_wdata == 8'd0) ? PH_DONE : PH_CMD;
      state.held_command  <= 8'd0;
      state.args_left     <= 7'd0;
      state.delay_follows <= 1'b0;
      state.commands_left <= cfg_wdata;
    end else if (advance) begin
      state <= state_next;
    end
  end

  dils_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (load_beat),
    .load_result (step_result),
    .out_stall   (out_stall),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_result  (out_result)
  );

  assign kind     = out_result.kind;
  assign out_byte = out_result.out_byte;
  assign delay_ms = out_result.delay_ms;
  assign last     = out_result.last;

  // once done, only a config write or reset leaves the done phase
  `DILS_ASSERT_NEXT(a_done_sticks, state.phase == PH_DONE && !cfg_we, state.phase == PH_DONE)
  // a beat marked last always closes the sequence
  `DILS_ASSERT_NEXT(a_last_ends, load_beat && step_result.last && !cfg_we, state.phase == PH_DONE)
  // argument phase never runs with an empty argument count
  `DILS_ASSERT_NOW(a_args_nonzero, state.phase == PH_ARGS, state.args_left != 7'd0)
  // stall only with a byte held
  `DILS_ASSERT_NOW(a_stall_full, in_stall, in_full && out_valid)

endmodule

[tb/tb_display_init_list_sequencer.sv]
// testbench for the display init list sequencer: random lists checked beat by beat
`timescale 1ns / 1ps
module tb_display_init_list_sequencer import dils_pkg::*; ();

  // run limits
  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 8;    // covers input register plus result register
  localparam int HoldCycles  = 300;  // long receiver hold-off
  localparam int MinBytes    = 1550;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] list_byte = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [8:0] delay_ms;
  logic       last;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  display_init_list_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .list_byte (list_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .out_byte  (out_byte),
    .delay_ms  (delay_ms),
    .last      (last),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // list bytes waiting to be driven, and the results the list should produce
  logic [7:0]   pending_bytes[$];
  dils_result_t expected_results[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  bytes_queued = 0;
  bit  in_beat_taken = 1'b0;
  bit  out_beat_taken = 1'b0;
  int  send_gap = 0;
  int  rx_wait = 0;
  bit  sender_idles = 1'b1;
  bit  receiver_idles = 1'b1;
  bit  hold_go = 1'b0;
  bit  rx_hold = 1'b0;

  // predicted interpreter state
  logic [7:0] cmd_total;
  phase_t     stage;
  logic [7:0] kept_cmd;
  logic [6:0] args_remaining;
  logic       delay_pending;
  logic [7:0] entries_left;

  // back to the start of the list, entry count reloaded
  function automatic void restart_list();
    kept_cmd       = '0;
    args_remaining = '0;
    delay_pending  = 1'b0;
    entries_left   = cmd_total;
    stage          = (entries_left == 0) ? PH_DONE : PH_CMD;
  endfunction

  // one entry complete; high when it was the final one
  function automatic logic finish_entry();
    entries_left = entries_left - 8'd1;
    if (entries_left == 0) begin
      stage = PH_DONE;
      return 1'b1;
    end
    stage = PH_CMD;
    return 1'b0;
  endfunction

  // advance the list parser by one byte and queue the result it yields, if any
  function automatic void interpret_byte(logic [7:0] b);
    dils_result_t r;
    bit           produce;
    r = '0;
    produce = 1'b1;
    case (stage)
      PH_CMD: begin
        // command byte is only held until its count byte shows up
        kept_cmd = b;
        stage = PH_COUNT;
        produce = 1'b0;
      end
      PH_COUNT: begin
        args_remaining = b[6:0];
        delay_pending  = b[DelayFlagBit];
        if (args_remaining != 0) begin
          stage = PH_ARGS;
        end else if (delay_pending) begin
          stage = PH_DELAY;
        end else begin
          r.last = finish_entry();
        end
        r.kind = KIND_CMD;
        r.out_byte = kept_cmd;
      end
      PH_ARGS: begin
        args_remaining = args_remaining - 7'd1;
        if (args_remaining == 0) begin
          if (delay_pending) begin
            stage = PH_DELAY;
          end else begin
            r.last = finish_entry();
          end
        end
        r.kind = KIND_DATA;
        r.out_byte = b;
      end
      PH_DELAY: begin
        // the long-delay key stands for half a second; zero still gives a request
        r.kind = KIND_DELAY;
        r.delay_ms = (b == LongDelayKey) ? LongDelayMs : {1'b0, b};
        r.last = finish_entry();
      end
      default: begin
        produce = 1'b0;
      end
    endcase
    if (produce) begin
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(string what, logic [8:0] want, logic [8:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // compare one accepted result beat against the oldest prediction
  function automatic void check_result();
    dils_result_t want;
    if (expected_results.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result, expected none, got kind %0d byte %0d ms %0d last %0d",
               $time, kind, out_byte, delay_ms, last);
      return;
    end
    want = expected_results.pop_front();
    check_field("kind", 9'(want.kind), 9'(kind));
    check_field("out_byte", 9'(want.out_byte), 9'(out_byte));
    check_field("delay_ms", want.delay_ms, delay_ms);
    check_field("last", 9'(want.last), 9'(last));
  endfunction

  // rising edge: note both handshakes, track config writes and list bytes,
  // check results, and stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    in_beat_taken  = !rst && in_valid && !in_stall;
    out_beat_taken = !rst && out_valid && !out_stall;
    if (rst) begin
      cmd_total = CountReset;
      restart_list();
    end else begin
      if (cfg_we) begin
        // a count write restarts the parser
        cmd_total = cfg_wdata;
        restart_list();
      end else if (in_beat_taken) begin
        interpret_byte(list_byte);
      end
      if (out_beat_taken) begin
        check_result();
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("tb_display_init_list_sequencer NOT OK");
      $finish;
    end
  end

  // sender: a new beat goes out once the previous one was taken and its gap ran out
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        in_valid  <= 1'b1;
        list_byte <= pending_bytes.pop_front();
        send_gap  = sender_idles ? $urandom_range(0, 14) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: a fresh stall count per result beat, plus the long hold-off
  always @(negedge clk) begin
    if (out_beat_taken) begin
      rx_wait = receiver_idles ? $urandom_range(0, 14) : 0;
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (rx_hold) begin
      out_stall <= 1'b1;
    end else if (rx_wait > 0 && out_valid) begin
      rx_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // long hold-off, counted here so the sender keeps pushing and the block backs up
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic queue_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_queued++;
  endtask

  // one list entry: command, count with delay flag, arguments, optional delay byte
  task automatic queue_entry(logic [7:0] cmd, int nargs, bit with_delay, logic [7:0] dly);
    logic [7:0] count_byte;
    count_byte = {1'b0, 7'(nargs)};
    count_byte[DelayFlagBit] = with_delay;
    queue_byte(cmd);
    queue_byte(count_byte);
    repeat (nargs) queue_byte(8'($urandom));
    if (with_delay) begin
      queue_byte(dly);
    end
  endtask

  task automatic queue_random_entry();
    int         pick;
    int         nargs;
    logic [7:0] dly;
    pick = $urandom_range(0, 99);
    // mostly short argument lists, now and then a long or a full one
    if (pick < 1) begin
      nargs = 127;
    end else if (pick < 8) begin
      nargs = $urandom_range(7, 40);
    end else begin
      nargs = $urandom_range(0, 6);
    end
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      dly = LongDelayKey;
    end else if (pick < 4) begin
      dly = 8'd0;
    end else begin
      dly = 8'($urandom);
    end
    queue_entry(8'($urandom), nargs, 1'($urandom_range(0, 1)), dly);
  endtask

  // everything driven, every result back, and the pipe given time to empty
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_count(logic [7:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int cnt;
    int style;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // directed list at the reset count of 14 entries
    queue_entry(8'h00, 0, 1'b0, 8'h00);           // no args, no delay
    queue_entry(8'hFF, 0, 1'b1, 8'h00);           // delay only, zero ms
    queue_entry(8'hA5, 2, 1'b1, LongDelayKey);    // args then long delay
    queue_entry(8'h5A, 1, 1'b0, 8'h00);
    queue_entry(8'h3C, 1, 1'b1, 8'd254);
    repeat (9) queue_random_entry();
    repeat (3) queue_byte(8'($urandom));          // past the end, ignored

    // empty sequence: nothing comes out
    write_count(8'd0);
    repeat (12) queue_byte(8'($urandom));

    // single entry with the full argument count and a delay
    write_count(8'd1);
    queue_entry(8'h2C, 127, 1'b1, LongDelayKey);
    repeat (3) queue_byte(8'($urandom));

    // largest count, restarted part way through
    write_count(8'd255);
    repeat (20) queue_random_entry();

    // back-to-back sender against a receiver that holds off for a long time
    write_count(8'd40);
    sender_idles = 1'b0;
    hold_go = 1'b1;
    repeat (40) queue_random_entry();
    repeat (4) queue_byte(8'($urandom));

    while (bytes_queued < MinBytes) begin
      cnt = $urandom_range(0, 19);
      if (cnt == 0) begin
        cnt = 0;
      end else if (cnt == 1) begin
        cnt = 255;
      end else if (cnt == 2) begin
        cnt = 1;
      end else begin
        cnt = $urandom_range(1, 24);
      end
      write_count(8'(cnt));
      // some phases run without any idling on one or both sides
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      style = $urandom_range(0, 9);
      if (style < 7) begin
        // whole list (20 entries for the largest count), then a few stray bytes
        repeat ((cnt == 255) ? 20 : cnt) queue_random_entry();
        repeat ($urandom_range(0, 3)) queue_byte(8'($urandom));
      end else if (style < 9) begin
        // list cut off inside an entry, restarted by the next write
        repeat ($urandom_range(0, (cnt > 5) ? 5 : cnt)) queue_random_entry();
        queue_byte(8'($urandom));
        if ($urandom_range(0, 1)) begin
          queue_byte(8'h85);
          repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));
        end
      end else begin
        // raw noise
        repeat ($urandom_range(5, 40)) queue_byte(8'($urandom));
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_display_init_list_sequencer OK");
    end else begin
      $display("tb_display_init_list_sequencer NOT OK");
    end
    $finish;
  end

endmodule
